[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int PAY_W = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef enum logic [2:0] {
    DP_NOP    = 3'd0,
    DP_INSERT = 3'd1,
    DP_POP    = 3'd2,
    DP_PEEK   = 3'd3,
    DP_CLEAR  = 3'd4
  } dp_op_t;

  typedef struct packed {
    cmd_code_t          cmd;
    logic [KEY_W-1:0]   item_key;
    logic [PAY_W-1:0]   item_payload;
  } in_item_t;

  typedef struct packed {
    status_code_t       status;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
  } out_item_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
    logic   desc;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
// Controller: handshake state machine, command decode and order register.
`default_nettype none
module spq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire spq_pkg::cmd_code_t   in_cmd,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output spq_pkg::status_code_t     out_status,
  output spq_pkg::dp_cmd_t          dp_cmd,
  input  wire spq_pkg::dp_stat_t    dp_stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } ctl_state_t;

  ctl_state_t            state_r, state_nxt;
  logic                  order_r, order_nxt;
  spq_pkg::status_code_t status_r, status_nxt;
  spq_pkg::dp_op_t       op;
  logic                  accept;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE) || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = (state_r == S_HOLD);
  assign out_status = status_r;

  always_comb begin
    op         = spq_pkg::DP_NOP;
    status_nxt = spq_pkg::ST_OK;
    case (in_cmd)
      spq_pkg::CMD_INSERT: begin
        if (dp_stat.full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          op = spq_pkg::DP_INSERT;
        end
      end
      spq_pkg::CMD_POP: begin
        if (dp_stat.empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          op = spq_pkg::DP_POP;
        end
      end
      spq_pkg::CMD_PEEK: begin
        if (dp_stat.empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          op = spq_pkg::DP_PEEK;
        end
      end
      spq_pkg::CMD_CLEAR: begin
        op = spq_pkg::DP_CLEAR;
      end
      default: begin
        op = spq_pkg::DP_NOP;
      end
    endcase
    if (!accept) begin
      status_nxt = status_r;
    end
  end

  assign dp_cmd.load = accept;
  assign dp_cmd.op   = op;
  assign dp_cmd.desc = order_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end else if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign order_nxt = (cfg_valid && cfg_ready) ? cfg_data : order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      order_r  <= 1'b0;
      status_r <= spq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      order_r  <= order_nxt;
      status_r <= status_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/spq_datapath.sv]
// Datapath: sorted slot chain with parallel compare, entry count and front output register.
`default_nettype none
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire spq_pkg::dp_cmd_t           dp_cmd,
  output spq_pkg::dp_stat_t               dp_stat,
  input  wire logic [spq_pkg::KEY_W-1:0]  item_key,
  input  wire logic [spq_pkg::PAY_W-1:0]  item_payload,
  output logic [spq_pkg::KEY_W-1:0]       front_key,
  output logic [spq_pkg::PAY_W-1:0]       front_payload
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LVLS  = $clog2(DEPTH);

  logic [spq_pkg::KEY_W-1:0] key_r   [DEPTH];
  logic [spq_pkg::KEY_W-1:0] key_nxt [DEPTH];
  logic [spq_pkg::PAY_W-1:0] pay_r   [DEPTH];
  logic [spq_pkg::PAY_W-1:0] pay_nxt [DEPTH];
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [spq_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic [spq_pkg::PAY_W-1:0] opay_r, opay_nxt;
  logic [DEPTH-1:0]          prec;
  logic [DEPTH-1:0]          pre [LVLS+1];
  logic [DEPTH-1:0]          hit_before;

  assign dp_stat.empty = (count_r == '0);
  assign dp_stat.full  = (count_r == CNT_W'(DEPTH));

  // The new entry precedes an occupied slot; a prefix OR finds every slot behind the first hit.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prec[i] = (CNT_W'(i) < count_r) &&
                (dp_cmd.desc ? (item_key > key_r[i]) : (item_key < key_r[i]));
    end
    pre[0] = prec;
    for (int lv = 0; lv < LVLS; lv++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << lv)) begin
          pre[lv+1][i] = pre[lv][i] | pre[lv][i - (1 << lv)];
        end else begin
          pre[lv+1][i] = pre[lv][i];
        end
      end
    end
    hit_before = {pre[LVLS][DEPTH-2:0], 1'b0};
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      key_nxt[i] = key_r[i];
      pay_nxt[i] = pay_r[i];
    end
    count_nxt = count_r;
    okey_nxt  = okey_r;
    opay_nxt  = opay_r;
    if (dp_cmd.load) begin
      case (dp_cmd.op)
        spq_pkg::DP_INSERT: begin
          for (int i = 1; i < DEPTH; i++) begin
            if (hit_before[i] && (CNT_W'(i) <= count_r)) begin
              key_nxt[i] = key_r[i-1];
              pay_nxt[i] = pay_r[i-1];
            end
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (!hit_before[i] && (prec[i] || (count_r == CNT_W'(i)))) begin
              key_nxt[i] = item_key;
              pay_nxt[i] = item_payload;
            end
          end
          count_nxt = count_r + CNT_W'(1);
          okey_nxt  = '0;
          opay_nxt  = '0;
        end
        spq_pkg::DP_POP: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            key_nxt[i] = key_r[i+1];
            pay_nxt[i] = pay_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
          okey_nxt  = key_r[0];
          opay_nxt  = pay_r[0];
        end
        spq_pkg::DP_PEEK: begin
          okey_nxt = key_r[0];
          opay_nxt = pay_r[0];
        end
        spq_pkg::DP_CLEAR: begin
          count_nxt = '0;
          okey_nxt  = '0;
          opay_nxt  = '0;
        end
        default: begin
          okey_nxt = '0;
          opay_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      key_r[i] <= key_nxt[i];
      pay_r[i] <= pay_nxt[i];
    end
    okey_r <= okey_nxt;
    opay_r <= opay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign front_key     = okey_r;
  assign front_payload = opay_r;

endmodule
`default_nettype wire

[rtl/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: controller, datapath and assertions.
`default_nettype none
// Bounded priority queue of DEPTH entries kept in sorted order, front first. Every
// transaction (insert, pop, peek or clear) is executed in the cycle in which it is
// accepted, and its result is registered and presented on the next cycle, so one
// transaction per clock is sustained while out_ready stays high. The figure is set by the
// slot chain, which compares the new key against all slots in parallel and shifts in one
// step. Equal keys leave in arrival order. The order register is written through the cfg
// channel and only affects later inserts.
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spq_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  spq_pkg::dp_cmd_t      dp_cmd;
  spq_pkg::dp_stat_t     dp_stat;
  spq_pkg::status_code_t out_status;
  logic [spq_pkg::KEY_W-1:0] front_key;
  logic [spq_pkg::PAY_W-1:0] front_payload;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_data.cmd),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat),
    .item_key      (in_data.item_key),
    .item_payload  (in_data.item_payload),
    .front_key     (front_key),
    .front_payload (front_payload)
  );

  assign out_data.status      = out_status;
  assign out_data.out_key     = front_key;
  assign out_data.out_payload = front_payload;

`ifndef NO_ASSERTIONS
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_stat.empty && dp_stat.full))
    else $error("queue reports empty and full at once");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == spq_pkg::CMD_CLEAR) |=> dp_stat.empty)
    else $error("clear transaction did not empty the queue");

  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == spq_pkg::CMD_INSERT && !dp_stat.full)
    |=> (!dp_stat.empty && out_valid && out_data.status == spq_pkg::ST_OK))
    else $error("insert transaction did not store an entry");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && dp_stat.empty &&
     (in_data.cmd == spq_pkg::CMD_POP || in_data.cmd == spq_pkg::CMD_PEEK))
    |=> (out_valid && out_data.status == spq_pkg::ST_EMPTY && out_data.out_key == '0))
    else $error("pop or peek on empty queue gave wrong result");
`endif

endmodule
`default_nettype wire

[dv/sorted_priority_queue_core_tb.sv]
// Testbench for the sorted priority queue: directed and random commands checked against a model.
`default_nettype none
module sorted_priority_queue_core_tb;

  localparam int QDEPTH = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  spq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  logic [spq_pkg::KEY_W-1:0] mirror_key [QDEPTH];
  logic [spq_pkg::PAY_W-1:0] mirror_payload [QDEPTH];
  int                        mirror_count = 0;
  bit                        order_desc = 1'b0;
  spq_pkg::out_item_t        pending_results [$];

  bit idle_on = 1'b1;
  int hold_request = 0;
  int stall_left = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_cfg = 0;

  sorted_priority_queue_core #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic spq_pkg::out_item_t apply_queue_cmd(spq_pkg::in_item_t it);
    spq_pkg::out_item_t r;
    int pos;
    int i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (it.cmd)
      spq_pkg::CMD_INSERT: begin
        if (mirror_count >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          pos = mirror_count;
          for (i = mirror_count - 1; i >= 0; i--) begin
            if (order_desc ? (it.item_key > mirror_key[i]) : (it.item_key < mirror_key[i]))
              pos = i;
          end
          for (i = mirror_count; i > pos; i--) begin
            mirror_key[i] = mirror_key[i-1];
            mirror_payload[i] = mirror_payload[i-1];
          end
          mirror_key[pos] = it.item_key;
          mirror_payload[pos] = it.item_payload;
          mirror_count++;
        end
      end
      spq_pkg::CMD_POP, spq_pkg::CMD_PEEK: begin
        if (mirror_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.out_key = mirror_key[0];
          r.out_payload = mirror_payload[0];
          if (it.cmd == spq_pkg::CMD_POP) begin
            for (i = 1; i < mirror_count; i++) begin
              mirror_key[i-1] = mirror_key[i];
              mirror_payload[i-1] = mirror_payload[i];
            end
            mirror_count--;
          end
        end
      end
      default: mirror_count = 0;
    endcase
    return r;
  endfunction

  task automatic send_cmd(spq_pkg::cmd_code_t cmd, logic [spq_pkg::KEY_W-1:0] key,
                          logic [spq_pkg::PAY_W-1:0] pay);
    spq_pkg::in_item_t it;
    it.cmd = cmd;
    it.item_key = key;
    it.item_payload = pay;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_queue_cmd(it));
    n_sent++;
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(bit desc);
    cfg_valid <= 1'b1;
    cfg_data <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order_desc = desc;
    n_cfg++;
  endtask

  function automatic spq_pkg::in_item_t random_cmd(int ins_pct);
    spq_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct)
      it.cmd = spq_pkg::CMD_INSERT;
    else if (pick >= 97)
      it.cmd = spq_pkg::CMD_CLEAR;
    else if ($urandom_range(0, 2) == 0)
      it.cmd = spq_pkg::CMD_PEEK;
    else
      it.cmd = spq_pkg::CMD_POP;
    case ($urandom_range(0, 3))
      0: it.item_key = 16'($urandom_range(0, 3));
      1: it.item_key = 16'hFFFF - 16'($urandom_range(0, 3));
      2: it.item_key = 16'(1000 + $urandom_range(0, 7));
      default: it.item_key = 16'($urandom);
    endcase
    it.item_payload = 16'($urandom);
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("Unexpected result: status %0d key %h payload %h",
                   out_data.status, out_data.out_key, out_data.out_payload);
      end else begin
        spq_pkg::out_item_t want;
        want = pending_results.pop_front();
        if (want.status !== out_data.status || want.out_key !== out_data.out_key ||
            want.out_payload !== out_data.out_payload) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("Result %0d differs: status %0d/%0d key %h/%h payload %h/%h (exp/act)",
                     n_checked, want.status, out_data.status, want.out_key,
                     out_data.out_key, want.out_payload, out_data.out_payload);
        end
      end
    end
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_empty_queue();
    send_cmd(spq_pkg::CMD_POP, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_PEEK, 16'hFFFF, 16'hFFFF);
    send_cmd(spq_pkg::CMD_CLEAR, 16'h5A5A, 16'hA5A5);
  endtask

  task automatic test_ascending_basics();
    send_cmd(spq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send_cmd(spq_pkg::CMD_INSERT, 16'h8000, 16'h1234);
    send_cmd(spq_pkg::CMD_INSERT, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_INSERT, 16'h8000, 16'h5678);
    send_cmd(spq_pkg::CMD_PEEK, 16'h0000, 16'h0000);
    repeat (4) send_cmd(spq_pkg::CMD_POP, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_POP, 16'h0000, 16'h0000);
  endtask

  task automatic test_descending_and_switch();
    wait_for_results();
    write_order(1'b1);
    send_cmd(spq_pkg::CMD_INSERT, 16'h0100, 16'h0001);
    send_cmd(spq_pkg::CMD_INSERT, 16'hFFFF, 16'h0002);
    send_cmd(spq_pkg::CMD_INSERT, 16'h0100, 16'h0003);
    wait_for_results();
    write_order(1'b0);
    send_cmd(spq_pkg::CMD_INSERT, 16'h0050, 16'h0004);
    send_cmd(spq_pkg::CMD_INSERT, 16'h0200, 16'h0005);
    send_cmd(spq_pkg::CMD_PEEK, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_POP, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_CLEAR, 16'h0000, 16'h0000);
    send_cmd(spq_pkg::CMD_PEEK, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic(int count, int ins_pct, bit allow_idle);
    spq_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      idle_on = allow_idle && ((i / 40) % 2 == 0);
      it = random_cmd(ins_pct);
      send_cmd(it.cmd, it.item_key, it.item_payload);
      if (idle_on && $urandom_range(0, 3) == 0)
        pause_input($urandom_range(1, 3));
    end
  endtask

  task automatic test_backpressure();
    spq_pkg::in_item_t it;
    wait_for_results();
    write_order(1'b1);
    hold_request = 80;
    for (int i = 0; i < 60; i++) begin
      it = random_cmd(75);
      send_cmd(it.cmd, it.item_key, it.item_payload);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_ascending_basics();
    test_descending_and_switch();
    test_random_traffic(200, 55, 1'b1);
    test_backpressure();
    write_order(1'b0);
    test_random_traffic(200, 30, 1'b1);
    wait_for_results();
    idle_on = 1'b0;
    write_order(1'b1);
    test_random_traffic(220, 60, 1'b0);
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d commands in both key orders (%0d order writes); checked %0d results,",
             n_sent, n_cfg, n_checked);
    $display("including %0d full rejections and %0d empty responses.", n_full, n_empty);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
